[design/adc_sma_pkg.sv]
`timescale 1ns / 1ps

package adc_sma_pkg;

  localparam int unsigned NUM_CHANNELS   = 4;
  localparam int unsigned AVERAGE_POINTS = 4;
  localparam int unsigned SAMPLE_BITS    = 10;

  localparam int unsigned CH_BITS     = $clog2(NUM_CHANNELS);
  localparam int unsigned SLOT_BITS   = $clog2(AVERAGE_POINTS);
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
  localparam int unsigned REQ_CH_BITS = 8;

  localparam logic ACTION_CONVERT = 1'b0;
  localparam logic ACTION_READ    = 1'b1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] read_value;
    logic [CH_BITS-1:0]     next_channel;
    logic                   start_conversion;
  } adc_sma_result_t;

endpackage

[design/adc_sma_core.sv]
`timescale 1ns / 1ps

module adc_sma_core import adc_sma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   accept_i,
  input  logic                   action_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [REQ_CH_BITS-1:0] channel_i,
  output adc_sma_result_t        result_o
);

  logic                   avg_en_q;
  logic [CH_BITS-1:0]     cur_ch_q, cur_ch_d;
  logic [SLOT_BITS-1:0]   slot_q, slot_d;
  logic [SAMPLE_BITS-1:0] store_q [NUM_CHANNELS][AVERAGE_POINTS];

  logic                   is_conv;
  logic                   ch_in_range;
  logic [CH_BITS-1:0]     rd_ch;
  logic [SUM_BITS-1:0]    row_sum;
  logic [SUM_BITS-1:0]    avg_full;
  logic [SAMPLE_BITS-1:0] rd_value;

  assign is_conv = (action_i == ACTION_CONVERT);

  // channel advance, slot advances on wrap only with averaging on
  always_comb begin
    cur_ch_d = cur_ch_q;
    slot_d   = slot_q;
    if (cur_ch_q == CH_BITS'(NUM_CHANNELS - 1)) begin
      cur_ch_d = '0;
      if (avg_en_q) begin
        if (slot_q == SLOT_BITS'(AVERAGE_POINTS - 1)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
    end else begin
      cur_ch_d = cur_ch_q + 1'b1;
    end
  end

  assign ch_in_range = (channel_i < REQ_CH_BITS'(NUM_CHANNELS));
  assign rd_ch       = channel_i[CH_BITS-1:0];

  always_comb begin
    row_sum = '0;
    for (int k = 0; k < AVERAGE_POINTS; k++) begin
      row_sum = row_sum + SUM_BITS'(store_q[rd_ch][k]);
    end
  end

  assign avg_full = row_sum >> SLOT_BITS;

  always_comb begin
    rd_value = '0;
    if (ch_in_range) begin
      if (avg_en_q) begin
        rd_value = avg_full[SAMPLE_BITS-1:0];
      end else begin
        rd_value = store_q[rd_ch][slot_q];
      end
    end
  end

  always_comb begin
    result_o.read_value       = is_conv ? '0 : rd_value;
    result_o.next_channel     = is_conv ? cur_ch_d : cur_ch_q;
    result_o.start_conversion = is_conv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_en_q <= 1'b1;
      cur_ch_q <= '0;
      slot_q   <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        for (int k = 0; k < AVERAGE_POINTS; k++) begin
          store_q[c][k] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        avg_en_q <= cfg_wdata_i;
      end
      if (accept_i && is_conv) begin
        store_q[cur_ch_q][slot_q] <= sample_i;
        cur_ch_q                  <= cur_ch_d;
        slot_q                    <= slot_d;
      end
    end
  end

endmodule

[design/adc_sma_outbuf.sv]
`timescale 1ns / 1ps

module adc_sma_outbuf import adc_sma_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  adc_sma_result_t result_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output adc_sma_result_t result_o
);

  logic            out_valid_q;
  logic            skid_valid_q;
  adc_sma_result_t out_q;
  adc_sma_result_t skid_q;
  logic            in_accept;
  logic            out_take;

  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_accept) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= result_i;
      end else begin
        skid_q <= result_i;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_blocked_goes_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("transaction accepted behind a stalled output was dropped");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !skid_valid_q && !in_accept) |=> !out_valid_q)
    else $error("output transaction repeated after it was taken");

endmodule

[design/adc_scan_moving_average_unit.sv]
`timescale 1ns / 1ps

// Round-robin scanner for four multiplexed ADC channels with a four-point
// moving average per channel. A conversion transaction (action 0) stores its
// sample for the channel now selected in the current filter slot, steps the
// channel and, on wrap-around with averaging on, the slot; its result reports
// the channel to convert next and raises start_conversion. A read transaction
// (action 1) returns the mean of the channel's four stored samples, or with
// averaging_enable cleared the sample at the current slot; channels above 3
// read as zero. One transaction is taken every clock while in_stall_o is low:
// the whole job is one pass of logic from the inputs and the 16-entry sample
// store (flip-flops, zero at reset) into the result register. A two-entry
// output buffer keeps input acceptance going while a result waits;
// in_stall_o rises only when both entries are full.
// Write averaging_enable (reset 1) through cfg_we_i/cfg_wdata_i while idle.

module adc_scan_moving_average_unit import adc_sma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [REQ_CH_BITS-1:0] channel_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] read_value_o,
  output logic [CH_BITS-1:0]     next_channel_o,
  output logic                   start_conversion_o
);

  adc_sma_result_t core_result;
  adc_sma_result_t buf_result;
  logic            accept;

  // transaction accepted on input side
  assign accept = in_valid_i && !in_stall_o;

  adc_sma_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .channel_i   (channel_i),
    .result_o    (core_result)
  );

  adc_sma_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .result_i    (core_result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (buf_result)
  );

  assign read_value_o       = buf_result.read_value;
  assign next_channel_o     = buf_result.next_channel;
  assign start_conversion_o = buf_result.start_conversion;

endmodule
